// ===== hw/rtl/shst_pkg.sv =====
package shst_pkg;

    // Table size and field widths
    localparam int MAX_SHAPES = 16;
    localparam int COUNT_W    = 5;
    localparam int INDEX_W    = 4;
    localparam int KIND_W     = 2;
    localparam int COORD_W    = 16;

    // Derived arithmetic widths
    localparam int DIFF_W = COORD_W + 1;        // corner difference
    localparam int PROD_W = COORD_W + DIFF_W;   // coordinate times difference
    localparam int AREA_W = PROD_W + 2;         // sum of three products
    localparam int SUM_W  = PROD_W + 2;         // edge function value
    localparam int ST_W   = SUM_W + 1;          // s + t

    // Pipeline depth, input register to result register
    localparam int STAGES = 9;

    // Shape kinds
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RECT    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TRI     = 2'd2;

    // Commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef logic [KIND_W-1:0]         kind_t;
    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [AREA_W-1:0]  area_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic signed [ST_W-1:0]    st_t;

    // Geometry of one table entry: rectangle bounds plus the
    // orientation-corrected edge function coefficients of a triangle
    typedef struct packed {
        coord_t rx1;
        coord_t ry1;
        coord_t rx2;
        coord_t ry2;
        prod_t  as_c;
        diff_t  bs;
        diff_t  cs;
        prod_t  at_c;
        diff_t  bt;
        diff_t  ct;
        area_t  area;
    } geom_t;

endpackage

// ===== hw/rtl/shape_set_hit_tester.sv =====
// Shape-set hit tester. A table of MAX_SHAPES entries (rectangle, triangle or unknown,
// each with a sense flag) is loaded by write items; a query item returns one hit bit
// telling whether any entry below shape_count reports a hit for the point. The block
// takes one item per clock while no held result stalls it and presents a query result on
// hit through the nine register stages of the shared item pipeline (the first one is
// the input register): five stages precompute a written triangle's
// edge coefficients and signed area (differences, products, sums, orientation fix)
// before the entry lands in the table, and four stages evaluate every entry against
// a query in parallel (one multiplier cell per coefficient, then two adds, then the
// final compare and OR). Writes and queries move through the same stages, so a query
// sees exactly the writes taken before it. A stalled result freezes the whole pipe.
// The user must write shape_count only while no item is in flight; the block does not enforce it.
module shape_set_hit_tester (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            shape_count_we,
    input  logic [shst_pkg::COUNT_W-1:0]    shape_count_wdata,
    input  logic                            cmd_valid,
    output logic                            cmd_stall,
    input  logic                            command,
    input  logic [shst_pkg::INDEX_W-1:0]    shape_index,
    input  shst_pkg::kind_t                 shape_kind,
    input  logic                            should_collide,
    input  shst_pkg::coord_t                corner1_x,
    input  shst_pkg::coord_t                corner1_y,
    input  shst_pkg::coord_t                corner2_x,
    input  shst_pkg::coord_t                corner2_y,
    input  shst_pkg::coord_t                corner3_x,
    input  shst_pkg::coord_t                corner3_y,
    input  shst_pkg::coord_t                query_x,
    input  shst_pkg::coord_t                query_y,
    output logic                            hit_valid,
    input  logic                            hit_stall,
    output logic                            hit
);
    import shst_pkg::*;

    logic [COUNT_W-1:0] shape_count_reg;
    logic [STAGES-1:0]  vld_reg;
    logic [STAGES-1:0]  cmd_reg;
    logic               adv;
    logic               tbl_we;

    // Stage 1: captured item
    logic [INDEX_W-1:0] s1_idx_reg;
    kind_t              s1_kind_reg;
    logic               s1_sense_reg;
    coord_t             s1_x1_reg, s1_y1_reg, s1_x2_reg, s1_y2_reg, s1_x3_reg, s1_y3_reg;
    coord_t             s1_qx_reg, s1_qy_reg;

    // Stage 2: corner differences
    logic [INDEX_W-1:0] s2_idx_reg;
    kind_t              s2_kind_reg;
    logic               s2_sense_reg;
    coord_t             s2_x1_reg, s2_y1_reg, s2_x2_reg, s2_y2_reg, s2_x3_reg, s2_y3_reg;
    diff_t              s2_dy23_reg, s2_bs_reg, s2_cs_reg, s2_bt_reg, s2_ct_reg;
    coord_t             s2_qx_reg, s2_qy_reg;

    // Stage 3: products
    logic [INDEX_W-1:0] s3_idx_reg;
    kind_t              s3_kind_reg;
    logic               s3_sense_reg;
    coord_t             s3_x1_reg, s3_y1_reg, s3_x2_reg, s3_y2_reg;
    diff_t              s3_bs_reg, s3_cs_reg, s3_bt_reg, s3_ct_reg;
    prod_t              s3_pd1_reg, s3_pd2_reg, s3_pd3_reg;
    prod_t              s3_py1x3_reg, s3_px1y3_reg, s3_px1y2_reg, s3_py1x2_reg;
    coord_t             s3_qx_reg, s3_qy_reg;

    // Stage 4: sums, raw orientation
    logic [INDEX_W-1:0] s4_idx_reg;
    kind_t              s4_kind_reg;
    logic               s4_sense_reg;
    geom_t              s4_geom_reg;
    coord_t             s4_qx_reg, s4_qy_reg;

    // Stage 5: orientation-corrected entry, table write / table read
    logic [INDEX_W-1:0] s5_idx_reg;
    kind_t              s5_kind_reg;
    logic               s5_sense_reg;
    geom_t              s5_geom_reg;
    geom_t              s5_geom_next;
    coord_t             s5_qx_reg, s5_qy_reg;

    // Shape table
    kind_t              tbl_kind_reg  [MAX_SHAPES];
    logic               tbl_sense_reg [MAX_SHAPES];
    geom_t              tbl_geom_reg  [MAX_SHAPES];

    // Stages 6 to 8: one evaluation cell per table entry
    logic               s6_rect_reg  [MAX_SHAPES];
    logic               s6_tri_reg   [MAX_SHAPES];
    logic               s6_sense_reg [MAX_SHAPES];
    prod_t              s6_as_reg    [MAX_SHAPES];
    prod_t              s6_at_reg    [MAX_SHAPES];
    prod_t              s6_pbsx_reg  [MAX_SHAPES];
    prod_t              s6_pcsy_reg  [MAX_SHAPES];
    prod_t              s6_pbtx_reg  [MAX_SHAPES];
    prod_t              s6_pcty_reg  [MAX_SHAPES];
    area_t              s6_area_reg  [MAX_SHAPES];

    logic               s7_rect_reg  [MAX_SHAPES];
    logic               s7_tri_reg   [MAX_SHAPES];
    logic               s7_sense_reg [MAX_SHAPES];
    sum_t               s7_s_reg     [MAX_SHAPES];
    sum_t               s7_t_reg     [MAX_SHAPES];
    area_t              s7_area_reg  [MAX_SHAPES];

    logic               s8_rect_reg  [MAX_SHAPES];
    logic               s8_tri_reg   [MAX_SHAPES];
    logic               s8_sense_reg [MAX_SHAPES];
    logic               s8_spos_reg  [MAX_SHAPES];
    logic               s8_tpos_reg  [MAX_SHAPES];
    st_t                s8_st_reg    [MAX_SHAPES];
    area_t              s8_area_reg  [MAX_SHAPES];

    // Stage 9: result
    logic               hit_reg;
    logic               hit_next;

    // Handshake: the whole pipe moves unless a result is held
    assign hit_valid = vld_reg[STAGES-1] && (cmd_reg[STAGES-1] == CMD_QUERY);
    assign adv       = !(hit_valid && hit_stall);
    assign cmd_stall = !adv;
    assign hit       = hit_reg;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_count_reg <= '0;
        end
        else if (shape_count_we)
        begin
            shape_count_reg <= shape_count_wdata;
        end
    end

    // Valid and command bits travel with the items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            cmd_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], cmd_valid};
            cmd_reg <= {cmd_reg[STAGES-2:0], command};
        end
    end

    // Stages 1 to 4 of the item pipe
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_idx_reg   <= shape_index;
            s1_kind_reg  <= shape_kind;
            s1_sense_reg <= should_collide;
            s1_x1_reg    <= corner1_x;
            s1_y1_reg    <= corner1_y;
            s1_x2_reg    <= corner2_x;
            s1_y2_reg    <= corner2_y;
            s1_x3_reg    <= corner3_x;
            s1_y3_reg    <= corner3_y;
            s1_qx_reg    <= query_x;
            s1_qy_reg    <= query_y;

            s2_idx_reg   <= s1_idx_reg;
            s2_kind_reg  <= s1_kind_reg;
            s2_sense_reg <= s1_sense_reg;
            s2_x1_reg    <= s1_x1_reg;
            s2_y1_reg    <= s1_y1_reg;
            s2_x2_reg    <= s1_x2_reg;
            s2_y2_reg    <= s1_y2_reg;
            s2_x3_reg    <= s1_x3_reg;
            s2_y3_reg    <= s1_y3_reg;
            s2_dy23_reg  <= DIFF_W'(s1_y2_reg) - DIFF_W'(s1_y3_reg);
            s2_bs_reg    <= DIFF_W'(s1_y3_reg) - DIFF_W'(s1_y1_reg);
            s2_cs_reg    <= DIFF_W'(s1_x1_reg) - DIFF_W'(s1_x3_reg);
            s2_bt_reg    <= DIFF_W'(s1_y1_reg) - DIFF_W'(s1_y2_reg);
            s2_ct_reg    <= DIFF_W'(s1_x2_reg) - DIFF_W'(s1_x1_reg);
            s2_qx_reg    <= s1_qx_reg;
            s2_qy_reg    <= s1_qy_reg;

            // area terms: y3-y1 is bs, y1-y2 is bt
            s3_idx_reg   <= s2_idx_reg;
            s3_kind_reg  <= s2_kind_reg;
            s3_sense_reg <= s2_sense_reg;
            s3_x1_reg    <= s2_x1_reg;
            s3_y1_reg    <= s2_y1_reg;
            s3_x2_reg    <= s2_x2_reg;
            s3_y2_reg    <= s2_y2_reg;
            s3_bs_reg    <= s2_bs_reg;
            s3_cs_reg    <= s2_cs_reg;
            s3_bt_reg    <= s2_bt_reg;
            s3_ct_reg    <= s2_ct_reg;
            s3_pd1_reg   <= PROD_W'(s2_x1_reg) * PROD_W'(s2_dy23_reg);
            s3_pd2_reg   <= PROD_W'(s2_x2_reg) * PROD_W'(s2_bs_reg);
            s3_pd3_reg   <= PROD_W'(s2_x3_reg) * PROD_W'(s2_bt_reg);
            s3_py1x3_reg <= PROD_W'(s2_y1_reg) * PROD_W'(s2_x3_reg);
            s3_px1y3_reg <= PROD_W'(s2_x1_reg) * PROD_W'(s2_y3_reg);
            s3_px1y2_reg <= PROD_W'(s2_x1_reg) * PROD_W'(s2_y2_reg);
            s3_py1x2_reg <= PROD_W'(s2_y1_reg) * PROD_W'(s2_x2_reg);
            s3_qx_reg    <= s2_qx_reg;
            s3_qy_reg    <= s2_qy_reg;

            s4_idx_reg       <= s3_idx_reg;
            s4_kind_reg      <= s3_kind_reg;
            s4_sense_reg     <= s3_sense_reg;
            s4_geom_reg.rx1  <= s3_x1_reg;
            s4_geom_reg.ry1  <= s3_y1_reg;
            s4_geom_reg.rx2  <= s3_x2_reg;
            s4_geom_reg.ry2  <= s3_y2_reg;
            s4_geom_reg.as_c <= s3_py1x3_reg - s3_px1y3_reg;
            s4_geom_reg.bs   <= s3_bs_reg;
            s4_geom_reg.cs   <= s3_cs_reg;
            s4_geom_reg.at_c <= s3_px1y2_reg - s3_py1x2_reg;
            s4_geom_reg.bt   <= s3_bt_reg;
            s4_geom_reg.ct   <= s3_ct_reg;
            s4_geom_reg.area <= AREA_W'(s3_pd1_reg) + AREA_W'(s3_pd2_reg)
                                + AREA_W'(s3_pd3_reg);
            s4_qx_reg        <= s3_qx_reg;
            s4_qy_reg        <= s3_qy_reg;
        end
    end

    // Stage 5: flip all coefficients of a clockwise triangle
    always_comb
    begin
        s5_geom_next = s4_geom_reg;
        if (s4_geom_reg.area[AREA_W-1])
        begin
            s5_geom_next.as_c = -s4_geom_reg.as_c;
            s5_geom_next.bs   = -s4_geom_reg.bs;
            s5_geom_next.cs   = -s4_geom_reg.cs;
            s5_geom_next.at_c = -s4_geom_reg.at_c;
            s5_geom_next.bt   = -s4_geom_reg.bt;
            s5_geom_next.ct   = -s4_geom_reg.ct;
            s5_geom_next.area = -s4_geom_reg.area;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_idx_reg   <= s4_idx_reg;
            s5_kind_reg  <= s4_kind_reg;
            s5_sense_reg <= s4_sense_reg;
            s5_geom_reg  <= s5_geom_next;
            s5_qx_reg    <= s4_qx_reg;
            s5_qy_reg    <= s4_qy_reg;
        end
    end

    // Table write as a write item leaves stage 5; out-of-table indexes match no entry
    assign tbl_we = adv && vld_reg[4] && (cmd_reg[4] == CMD_WRITE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < MAX_SHAPES; e++)
            begin
                tbl_kind_reg[e]  <= KIND_UNKNOWN;
                tbl_sense_reg[e] <= 1'b1;
            end
        end
        else if (tbl_we)
        begin
            for (int e = 0; e < MAX_SHAPES; e++)
            begin
                if (32'(s5_idx_reg) == 32'(e))
                begin
                    tbl_kind_reg[e]  <= s5_kind_reg;
                    tbl_sense_reg[e] <= s5_sense_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            for (int e = 0; e < MAX_SHAPES; e++)
            begin
                if (32'(s5_idx_reg) == 32'(e))
                begin
                    tbl_geom_reg[e] <= s5_geom_reg;
                end
            end
        end
    end

    // Stages 6 to 8: per-entry cells fed from the table as the item leaves stage 5
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int e = 0; e < MAX_SHAPES; e++)
            begin
                // bounds test and coefficient products
                s6_rect_reg[e]  <= (tbl_kind_reg[e] == KIND_RECT)
                                   && (tbl_geom_reg[e].rx1 <= s5_qx_reg)
                                   && (s5_qx_reg <= tbl_geom_reg[e].rx2)
                                   && (tbl_geom_reg[e].ry1 <= s5_qy_reg)
                                   && (s5_qy_reg <= tbl_geom_reg[e].ry2);
                s6_tri_reg[e]   <= (tbl_kind_reg[e] == KIND_TRI);
                s6_sense_reg[e] <= tbl_sense_reg[e];
                s6_as_reg[e]    <= tbl_geom_reg[e].as_c;
                s6_at_reg[e]    <= tbl_geom_reg[e].at_c;
                s6_pbsx_reg[e]  <= PROD_W'(tbl_geom_reg[e].bs) * PROD_W'(s5_qx_reg);
                s6_pcsy_reg[e]  <= PROD_W'(tbl_geom_reg[e].cs) * PROD_W'(s5_qy_reg);
                s6_pbtx_reg[e]  <= PROD_W'(tbl_geom_reg[e].bt) * PROD_W'(s5_qx_reg);
                s6_pcty_reg[e]  <= PROD_W'(tbl_geom_reg[e].ct) * PROD_W'(s5_qy_reg);
                s6_area_reg[e]  <= tbl_geom_reg[e].area;

                // edge functions
                s7_rect_reg[e]  <= s6_rect_reg[e];
                s7_tri_reg[e]   <= s6_tri_reg[e];
                s7_sense_reg[e] <= s6_sense_reg[e];
                s7_s_reg[e]     <= SUM_W'(s6_as_reg[e]) + SUM_W'(s6_pbsx_reg[e])
                                   + SUM_W'(s6_pcsy_reg[e]);
                s7_t_reg[e]     <= SUM_W'(s6_at_reg[e]) + SUM_W'(s6_pbtx_reg[e])
                                   + SUM_W'(s6_pcty_reg[e]);
                s7_area_reg[e]  <= s6_area_reg[e];

                // strict positivity and s + t
                s8_rect_reg[e]  <= s7_rect_reg[e];
                s8_tri_reg[e]   <= s7_tri_reg[e];
                s8_sense_reg[e] <= s7_sense_reg[e];
                s8_spos_reg[e]  <= !s7_s_reg[e][SUM_W-1] && (s7_s_reg[e] != '0);
                s8_tpos_reg[e]  <= !s7_t_reg[e][SUM_W-1] && (s7_t_reg[e] != '0);
                s8_st_reg[e]    <= ST_W'(s7_s_reg[e]) + ST_W'(s7_t_reg[e]);
                s8_area_reg[e]  <= s7_area_reg[e];
            end
        end
    end

    // Stage 9: containment, sense, active range, OR over entries
    always_comb
    begin
        logic contained;
        hit_next = 1'b0;
        for (int e = 0; e < MAX_SHAPES; e++)
        begin
            contained = s8_rect_reg[e]
                        || (s8_tri_reg[e] && s8_spos_reg[e] && s8_tpos_reg[e]
                            && (s8_st_reg[e] < ST_W'(s8_area_reg[e])));
            if ((32'(e) < 32'(shape_count_reg)) && (s8_sense_reg[e] == contained))
            begin
                hit_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg <= hit_next;
        end
    end

`ifndef ASSERT_OFF
    // a held result freezes every stage
    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg) && $stable(cmd_reg))
        else $error("pipeline moved while result held");

    // a query leaving stage 8 shows up as a result
    a_query_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && vld_reg[STAGES-2] && (cmd_reg[STAGES-2] == CMD_QUERY)) |=> hit_valid)
        else $error("query item lost before result");

    // no table update while the pipe is frozen
    a_no_write_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (hit_valid && hit_stall) |-> !tbl_we)
        else $error("table written during stall");
`endif

endmodule
